/* hw/rtl/pmbfp_pkg.sv */
package pmbfp_pkg;

    // Field layout of the broadcast packet
    localparam int FIELD_COUNT  = 25;
    localparam int FIELD_W      = 5;
    localparam int HEADER_BYTES = 4;
    localparam int HDR_W        = 3;

    localparam logic [HDR_W-1:0]   HDR_MAGIC_POS = 3'd2;
    localparam logic [HDR_W-1:0]   HDR_BOARD_POS = 3'd3;
    localparam logic [HDR_W-1:0]   HDR_DONE      = 3'd4;
    localparam logic [7:0]         MAGIC_BYTE    = 8'hBB;
    localparam logic [FIELD_W-1:0] FIELD_NONE    = 5'd25;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_POLICY = 1'd1;
    localparam int CFG_DATA_W = 12;
    localparam int MAIN_W     = 11;
    localparam int EXTRA_W    = 12;

    // Bit f set: field f is four bytes long (others are two)
    localparam logic [FIELD_COUNT-1:0] FIELD_WIDE =
        (25'd1 << 0)  | (25'd1 << 4)  | (25'd1 << 5)  | (25'd1 << 6)  |
        (25'd1 << 7)  | (25'd1 << 13) | (25'd1 << 14) | (25'd1 << 15) |
        (25'd1 << 16) | (25'd1 << 19) | (25'd1 << 20);

    // Bit f set: two-byte field f is sign extended
    localparam logic [FIELD_COUNT-1:0] FIELD_SIGNED =
        (25'd1 << 1)  | (25'd1 << 2)  | (25'd1 << 11) | (25'd1 << 12) |
        (25'd1 << 22) | (25'd1 << 23) | (25'd1 << 24);

    // Result item
    typedef struct packed {
        logic [31:0]        value;
        logic [FIELD_W-1:0] field_id;
        logic [7:0]         board;
    } result_t;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

endpackage

/* hw/rtl/policy_masked_broadcast_field_parser.sv */
// Motor board broadcast field parser.
// s_ channel: one packet byte per request, s_tdata[7:0] = byte_value, s_tlast
// marks the final byte of the packet. Byte 2 must be 0xBB or the packet is
// ignored, byte 3 is the board number, and from byte 4 on the two policy
// masks pick little-endian fields of 2 or 4 bytes.
// m_ channel: one request per completed field, m_tdata = board [7:0],
// field_id [12:8], value [44:13], zeros above.
// cfg channel: index 0 writes main_policy, index 1 extra_policy; cfg_ready is
// always high. Write only while no packet is in flight.
// Throughput: one byte per cycle while s_tready is high, set by the combinational
// field search and byte merge between the input handshake and the output register.
// A completed field is loaded into the output register when its last byte is accepted.
// When the receiver stalls, one further result is held in a skid register;
// s_tready drops only while that skid register is full.
// Reset (aresetn low, synchronous) clears both policies, the packet state
// and the valid flags of the output and skid registers.
module policy_masked_broadcast_field_parser
    import pmbfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [7:0] byte_value
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [7:0] board, [12:8] field_id, [44:13] value
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAIN_W-1:0]  main_policy_reg;
    logic [EXTRA_W-1:0] extra_policy_reg;

    logic [HDR_W-1:0]   header_pos_reg, header_pos_next;
    logic               accepted_reg, accepted_next;
    logic [7:0]         board_reg, board_next;
    logic [FIELD_W-1:0] cur_field_reg, cur_field_next;
    logic [1:0]         byte_idx_reg, byte_idx_next;
    logic [23:0]        acc_reg, acc_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic                   in_fire;
    logic [7:0]             in_byte;
    logic [FIELD_COUNT-1:0] enabled;
    logic [FIELD_COUNT-1:0] candidates;
    logic [FIELD_W-1:0]     found;
    logic [FIELD_W-1:0]     sel_field;
    logic                   res_valid;
    result_t                res;
    logic                   field_done;
    logic [15:0]            short_val;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign in_byte   = s_tdata[7:0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - $bits(result_t)){1'b0}}, out_reg};

    // Latch policy registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_policy_reg  <= '0;
            extra_policy_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAIN_POLICY:  main_policy_reg  <= cfg_data[MAIN_W-1:0];
                CFG_EXTRA_POLICY: extra_policy_reg <= cfg_data[EXTRA_W-1:0];
                default: ;
            endcase
        end
    end

    // Build the field enable mask and keep fields at or after the current one
    assign enabled = {extra_policy_reg,
                      {4{main_policy_reg[9] & main_policy_reg[10]}},
                      main_policy_reg[8:0]};
    assign candidates = enabled & ({FIELD_COUNT{1'b1}} << cur_field_reg);

    // Find the lowest enabled field
    always_comb begin
        found = FIELD_NONE;
        for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
            if (candidates[i]) begin
                found = FIELD_W'(i);
            end
        end
    end

    assign sel_field = (byte_idx_reg == 2'd0) ? found : cur_field_reg;

    // Advance header, merge bytes and form the result
    always_comb begin
        header_pos_next = header_pos_reg;
        accepted_next   = accepted_reg;
        board_next      = board_reg;
        cur_field_next  = cur_field_reg;
        byte_idx_next   = byte_idx_reg;
        acc_next        = acc_reg;
        res_valid       = 1'b0;
        field_done      = 1'b0;
        short_val       = {in_byte, acc_reg[7:0]};
        res.board       = board_reg;
        res.field_id    = sel_field;
        res.value       = '0;

        if (sel_field != FIELD_NONE) begin
            if (FIELD_WIDE[sel_field]) begin
                field_done = (byte_idx_reg == 2'd3);
                res.value  = {in_byte, acc_reg};
            end else begin
                field_done = (byte_idx_reg != 2'd0);
                res.value  = {{16{FIELD_SIGNED[sel_field] & short_val[15]}}, short_val};
            end
        end

        if (in_fire) begin
            if (header_pos_reg != HDR_DONE) begin
                if (header_pos_reg == HDR_MAGIC_POS) begin
                    accepted_next = (in_byte == MAGIC_BYTE);
                end else if (header_pos_reg == HDR_BOARD_POS) begin
                    board_next = in_byte;
                end
                header_pos_next = header_pos_reg + 3'd1;
            end else if (accepted_reg) begin
                cur_field_next = sel_field;
                if (sel_field != FIELD_NONE) begin
                    if (field_done) begin
                        res_valid      = 1'b1;
                        cur_field_next = sel_field + 5'd1;
                        byte_idx_next  = 2'd0;
                        acc_next       = '0;
                    end else begin
                        acc_next      = acc_reg | (24'(in_byte) << {byte_idx_reg, 3'b000});
                        byte_idx_next = byte_idx_reg + 2'd1;
                    end
                end
            end

            // Drop all packet state after the final byte
            if (s_tlast) begin
                header_pos_next = '0;
                accepted_next   = 1'b0;
                board_next      = '0;
                cur_field_next  = '0;
                byte_idx_next   = '0;
                acc_next        = '0;
            end
        end
    end

    // Hold packet state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pos_reg <= '0;
            accepted_reg   <= 1'b0;
            board_reg      <= '0;
            cur_field_reg  <= '0;
            byte_idx_reg   <= '0;
            acc_reg        <= '0;
        end else begin
            header_pos_reg <= header_pos_next;
            accepted_reg   <= accepted_next;
            board_reg      <= board_next;
            cur_field_reg  <= cur_field_next;
            byte_idx_reg   <= byte_idx_next;
            acc_reg        <= acc_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    // A held skid result implies the output register is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    // Field pointer never passes the end marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_field_reg <= FIELD_NONE)
        else $error("current field out of range");

    // Partial fields exist only inside an accepted packet body
    assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_idx_reg != 2'd0) |-> (accepted_reg && header_pos_reg == HDR_DONE))
        else $error("field bytes collected outside accepted packet");

    // The final byte returns the parser to the start of a packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tlast) |=> (header_pos_reg == '0 && byte_idx_reg == 2'd0))
        else $error("packet state not cleared after last byte");

endmodule
